// ===== rtl/core/gsr_pkg.sv =====
// Shared types, constants and helper functions of the GJK simplex reducer.
// No dependencies; every other file of the block imports this package.
package gsr_pkg;

    localparam int IN_BITS     = 16;            // coordinate field width
    localparam int COORD_BITS  = 16;            // significant coordinate bits
    localparam int DIFF_BITS   = IN_BITS + 1;   // point difference
    localparam int DIR_BITS    = 56;            // direction / wide vector
    localparam int MUL_N_BITS  = 18;            // narrow multiplier operand
    localparam int PROD_BITS   = DIR_BITS + MUL_N_BITS;
    localparam int ACC_BITS    = PROD_BITS + 2;
    localparam int CNT_BITS    = 3;
    localparam int STEP_BITS   = 3;

    localparam logic [STEP_BITS-1:0] CROSS_TERMS = 3'd6;
    localparam logic [STEP_BITS-1:0] DOT_TERMS   = 3'd3;

    localparam logic [CNT_BITS-1:0] CNT_POINT = 3'd1;
    localparam logic [CNT_BITS-1:0] CNT_LINE  = 3'd2;
    localparam logic [CNT_BITS-1:0] CNT_TRI   = 3'd3;
    localparam logic [CNT_BITS-1:0] CNT_TETRA = 3'd4;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_WIND  = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    // vector registers of the datapath; the first four are narrow
    typedef enum logic [2:0] {
        SL_AB, SL_AC, SL_AD, SL_AO, SL_F, SL_T, SL_E
    } slot_t;

    typedef enum logic [2:0] {
        PT_NONE,
        PT_START,
        PT_PUSH,
        PT_COPY12,    // p1 = p2
        PT_TET_ACD,   // p1 = p2, p2 = p3
        PT_TET_ADB,   // p2 = p1, p1 = p3
        PT_SWAP12,
        PT_SWAP01
    } pt_op_t;

    typedef enum logic [1:0] {
        PREP_NONE,
        PREP_EVAL,
        PREP_WIND
    } prep_t;

    typedef enum logic {
        MAC_CROSS,
        MAC_DOT
    } mac_op_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_DISPATCH, ST_ROUTE,
        ST_L_PREP, ST_L_DOT, ST_L_TEST,
        ST_E_T, ST_E_D, ST_E_SET,
        ST_T_PREP, ST_T_ABC, ST_T_X1, ST_T_D1, ST_T_C1, ST_T_D2, ST_T_C2,
        ST_T_X2, ST_T_D3, ST_T_C3, ST_T_D4, ST_T_C4,
        ST_Q_PREP, ST_Q_X1, ST_Q_D1, ST_Q_C1, ST_Q_X2, ST_Q_D2, ST_Q_C2,
        ST_Q_X3, ST_Q_D3, ST_Q_C3,
        ST_W_PREP, ST_W_X, ST_W_D, ST_W_C,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic signed [IN_BITS-1:0] x;
        logic signed [IN_BITS-1:0] y;
        logic signed [IN_BITS-1:0] z;
    } point_t;

    typedef struct packed {
        logic signed [DIFF_BITS-1:0] x;
        logic signed [DIFF_BITS-1:0] y;
        logic signed [DIFF_BITS-1:0] z;
    } nvec_t;

    typedef struct packed {
        logic signed [DIR_BITS-1:0] x;
        logic signed [DIR_BITS-1:0] y;
        logic signed [DIR_BITS-1:0] z;
    } wvec_t;

    typedef struct packed {
        logic                load_in;
        pt_op_t              pt_op;
        prep_t               prep;
        logic                mac_run;
        mac_op_t             mac_op;
        slot_t               wsel;
        slot_t               nsel;
        logic                mac_neg;
        slot_t               dst;
        logic                dir_we;
        slot_t               dir_sel;
        logic                dir_neg;
        logic                cnt_we;
        logic [CNT_BITS-1:0] cnt_val;
        logic                hit_set;
        logic                out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        action_t             action;
        logic [CNT_BITS-1:0] count;
        logic                mac_done;
        logic                dot_pos;
    } dp_status_t;

    typedef struct packed {
        logic [1:0] wi;
        logic [1:0] ni;
        logic       neg;
        logic       last;
        logic [1:0] comp;
    } mac_term_t;

    // product terms: cross(W, N) takes two terms per component, dot takes three
    function automatic mac_term_t mac_term(mac_op_t op, logic [STEP_BITS-1:0] step);
        mac_term_t t;
        t = '0;
        case (op)
            MAC_DOT:
            begin
                t.wi   = step[1:0];
                t.ni   = step[1:0];
                t.last = (step == DOT_TERMS - 3'd1);
            end
            default:
            begin
                case (step)
                    3'd0:    begin t.wi = 2'd1; t.ni = 2'd2; t.neg = 1'b0; end
                    3'd1:    begin t.wi = 2'd2; t.ni = 2'd1; t.neg = 1'b1; end
                    3'd2:    begin t.wi = 2'd2; t.ni = 2'd0; t.neg = 1'b0; end
                    3'd3:    begin t.wi = 2'd0; t.ni = 2'd2; t.neg = 1'b1; end
                    3'd4:    begin t.wi = 2'd0; t.ni = 2'd1; t.neg = 1'b0; end
                    3'd5:    begin t.wi = 2'd1; t.ni = 2'd0; t.neg = 1'b1; end
                    default: begin t.wi = 2'd0; t.ni = 2'd0; t.neg = 1'b0; end
                endcase
                t.last = step[0];
                t.comp = step[2:1];
            end
        endcase
        return t;
    endfunction

    // keep the low COORD_BITS bits as a two's complement value
    function automatic logic signed [IN_BITS-1:0] sext_coord(logic [IN_BITS-1:0] raw);
        logic signed [IN_BITS-1:0] t;
        t = raw << (IN_BITS - COORD_BITS);
        return t >>> (IN_BITS - COORD_BITS);
    endfunction

endpackage

// ===== rtl/core/gsr_ifs.sv =====
// Valid/ready channel interfaces of the GJK simplex reducer.
// Depends on gsr_pkg for the payload widths.
interface gsr_item_if;
    import gsr_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [1:0]                action;
    logic signed [IN_BITS-1:0] vx;
    logic signed [IN_BITS-1:0] vy;
    logic signed [IN_BITS-1:0] vz;

    modport source (output valid, action, vx, vy, vz, input ready);
    modport sink   (input valid, action, vx, vy, vz, output ready);
endinterface

interface gsr_result_if;
    import gsr_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [DIR_BITS-1:0] dir_x;
    logic signed [DIR_BITS-1:0] dir_y;
    logic signed [DIR_BITS-1:0] dir_z;
    logic [CNT_BITS-1:0]        simplex_count;
    logic                       hit;

    modport source (output valid, dir_x, dir_y, dir_z, simplex_count, hit, input ready);
    modport sink   (input valid, dir_x, dir_y, dir_z, simplex_count, hit, output ready);
endinterface

// ===== rtl/core/gsr_datapath.sv =====
// Datapath of the GJK simplex reducer: point store, vector registers,
// shared multiply-accumulate unit and result register. Depends on gsr_pkg.
module gsr_datapath
    import gsr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ctrl_cmd_t                  cmd,
    output dp_status_t                 status,
    input  logic [1:0]                 action,
    input  logic signed [IN_BITS-1:0]  vx,
    input  logic signed [IN_BITS-1:0]  vy,
    input  logic signed [IN_BITS-1:0]  vz,
    output logic signed [DIR_BITS-1:0] dir_x,
    output logic signed [DIR_BITS-1:0] dir_y,
    output logic signed [DIR_BITS-1:0] dir_z,
    output logic [CNT_BITS-1:0]        simplex_count,
    output logic                       hit
);

    function automatic nvec_t diff3(point_t a, point_t b);
        nvec_t r;
        r.x = DIFF_BITS'(a.x) - DIFF_BITS'(b.x);
        r.y = DIFF_BITS'(a.y) - DIFF_BITS'(b.y);
        r.z = DIFF_BITS'(a.z) - DIFF_BITS'(b.z);
        return r;
    endfunction

    function automatic wvec_t widen(nvec_t n);
        wvec_t r;
        r.x = DIR_BITS'(n.x);
        r.y = DIR_BITS'(n.y);
        r.z = DIR_BITS'(n.z);
        return r;
    endfunction

    function automatic logic signed [DIR_BITS-1:0] wcomp(wvec_t v, logic [1:0] i);
        case (i)
            2'd0:    return v.x;
            2'd1:    return v.y;
            default: return v.z;
        endcase
    endfunction

    function automatic logic signed [DIFF_BITS-1:0] ncomp(nvec_t v, logic [1:0] i);
        case (i)
            2'd0:    return v.x;
            2'd1:    return v.y;
            default: return v.z;
        endcase
    endfunction

    function automatic wvec_t set_comp(wvec_t v, logic [1:0] i,
                                       logic signed [DIR_BITS-1:0] d);
        wvec_t r;
        r = v;
        case (i)
            2'd0:    r.x = d;
            2'd1:    r.y = d;
            default: r.z = d;
        endcase
        return r;
    endfunction

    action_t                     act_reg;
    point_t                      vin_reg;
    point_t                      pt_reg [4];
    point_t                      pt_next [4];
    logic [CNT_BITS-1:0]         cnt_reg, cnt_next;
    logic                        hit_reg, hit_next;
    wvec_t                       dir_reg, dir_next;
    nvec_t                       ab_reg, ab_next, ac_reg, ac_next;
    nvec_t                       ad_reg, ad_next, ao_reg, ao_next;
    wvec_t                       f_reg, f_next, t_reg, t_next, e_reg, e_next;
    logic [STEP_BITS-1:0]        step_reg, step_next;
    logic signed [PROD_BITS-1:0] prod_reg, prod_next;
    logic                        tneg_reg, tlast_reg;
    logic [1:0]                  tcomp_reg;
    logic signed [ACC_BITS-1:0]  acc_reg, acc_next;
    logic                        dotpos_reg, dotpos_next;
    wvec_t                       odir_reg;
    logic [CNT_BITS-1:0]         ocnt_reg;
    logic                        ohit_reg;

    wvec_t                       w_vec, dir_src;
    nvec_t                       n_vec;
    mac_term_t                   term;
    logic [STEP_BITS-1:0]        nterms;
    logic                        mac_done;
    logic                        acc_step;
    logic signed [PROD_BITS-1:0] prod_full;
    logic signed [ACC_BITS-1:0]  acc_sum;

    // operand selection
    always_comb
    begin
        case (cmd.wsel)
            SL_AB:   w_vec = widen(ab_reg);
            SL_AC:   w_vec = widen(ac_reg);
            SL_AD:   w_vec = widen(ad_reg);
            SL_AO:   w_vec = widen(ao_reg);
            SL_F:    w_vec = f_reg;
            SL_T:    w_vec = t_reg;
            SL_E:    w_vec = e_reg;
            default: w_vec = '0;
        endcase
        case (cmd.nsel)
            SL_AB:   n_vec = ab_reg;
            SL_AC:   n_vec = ac_reg;
            SL_AD:   n_vec = ad_reg;
            SL_AO:   n_vec = ao_reg;
            default: n_vec = '0;
        endcase
        case (cmd.dir_sel)
            SL_AO:   dir_src = widen(ao_reg);
            SL_F:    dir_src = f_reg;
            SL_T:    dir_src = t_reg;
            SL_E:    dir_src = e_reg;
            default: dir_src = '0;
        endcase
    end

    // multiply-accumulate: the product of term s is added at step s + 1
    assign term      = mac_term(cmd.mac_op, step_reg);
    assign nterms    = (cmd.mac_op == MAC_CROSS) ? CROSS_TERMS : DOT_TERMS;
    assign mac_done  = cmd.mac_run && (step_reg == nterms);
    assign acc_step  = cmd.mac_run && (step_reg != '0);
    assign prod_full = wcomp(w_vec, term.wi) * MUL_N_BITS'(ncomp(n_vec, term.ni));
    assign acc_sum   = tneg_reg ? (acc_reg - ACC_BITS'(prod_reg))
                                : (acc_reg + ACC_BITS'(prod_reg));

    always_comb
    begin
        step_next   = '0;
        prod_next   = prod_full;
        acc_next    = acc_reg;
        dotpos_next = dotpos_reg;
        f_next      = f_reg;
        t_next      = t_reg;
        e_next      = e_reg;
        if (cmd.mac_run && !mac_done)
        begin
            step_next = step_reg + 3'd1;
        end
        if (acc_step)
        begin
            if (tlast_reg)
            begin
                acc_next = '0;
                if (cmd.mac_op == MAC_DOT)
                begin
                    dotpos_next = !acc_sum[ACC_BITS-1] && (acc_sum != '0);
                end
                else
                begin
                    case (cmd.dst)
                        SL_F:    f_next = set_comp(f_reg, tcomp_reg, acc_sum[DIR_BITS-1:0]);
                        SL_T:    t_next = set_comp(t_reg, tcomp_reg, acc_sum[DIR_BITS-1:0]);
                        SL_E:    e_next = set_comp(e_reg, tcomp_reg, acc_sum[DIR_BITS-1:0]);
                        default: f_next = f_reg;
                    endcase
                end
            end
            else
            begin
                acc_next = acc_sum;
            end
        end
    end

    // differences for evaluation or winding check
    always_comb
    begin
        ab_next = ab_reg;
        ac_next = ac_reg;
        ad_next = ad_reg;
        ao_next = ao_reg;
        case (cmd.prep)
            PREP_EVAL:
            begin
                ab_next = diff3(pt_reg[1], pt_reg[0]);
                ac_next = diff3(pt_reg[2], pt_reg[0]);
                ad_next = diff3(pt_reg[3], pt_reg[0]);
                ao_next = diff3('0, pt_reg[0]);
            end
            PREP_WIND:
            begin
                ab_next = diff3(pt_reg[0], pt_reg[3]);
                ac_next = diff3(pt_reg[1], pt_reg[3]);
                ad_next = diff3(pt_reg[2], pt_reg[3]);
            end
            default:
            begin
                ab_next = ab_reg;
            end
        endcase
    end

    // point store, count, flag and direction
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pt_next[i] = pt_reg[i];
        end
        cnt_next = cnt_reg;
        hit_next = hit_reg;
        dir_next = dir_reg;
        case (cmd.pt_op)
            PT_START:
            begin
                pt_next[0] = vin_reg;
                pt_next[1] = '0;
                pt_next[2] = '0;
                pt_next[3] = '0;
                cnt_next   = CNT_POINT;
                hit_next   = 1'b0;
            end
            PT_PUSH:
            begin
                pt_next[0] = vin_reg;
                pt_next[1] = pt_reg[0];
                pt_next[2] = pt_reg[1];
                pt_next[3] = pt_reg[2];
                if (cnt_reg < CNT_TETRA)
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            PT_COPY12:
            begin
                pt_next[1] = pt_reg[2];
            end
            PT_TET_ACD:
            begin
                pt_next[1] = pt_reg[2];
                pt_next[2] = pt_reg[3];
            end
            PT_TET_ADB:
            begin
                pt_next[1] = pt_reg[3];
                pt_next[2] = pt_reg[1];
            end
            PT_SWAP12:
            begin
                pt_next[1] = pt_reg[2];
                pt_next[2] = pt_reg[1];
            end
            PT_SWAP01:
            begin
                pt_next[0] = pt_reg[1];
                pt_next[1] = pt_reg[0];
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
        if (cmd.cnt_we)
        begin
            cnt_next = cmd.cnt_val;
        end
        if (cmd.hit_set)
        begin
            hit_next = 1'b1;
        end
        if (cmd.dir_we)
        begin
            if (cmd.dir_neg)
            begin
                dir_next.x = -dir_src.x;
                dir_next.y = -dir_src.y;
                dir_next.z = -dir_src.z;
            end
            else
            begin
                dir_next = dir_src;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pt_reg[i] <= '0;
            end
            cnt_reg    <= CNT_POINT;
            hit_reg    <= 1'b0;
            dir_reg    <= '0;
            step_reg   <= '0;
            acc_reg    <= '0;
            dotpos_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                pt_reg[i] <= pt_next[i];
            end
            cnt_reg    <= cnt_next;
            hit_reg    <= hit_next;
            dir_reg    <= dir_next;
            step_reg   <= step_next;
            acc_reg    <= acc_next;
            dotpos_reg <= dotpos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            act_reg   <= action_t'(action);
            vin_reg.x <= sext_coord(vx);
            vin_reg.y <= sext_coord(vy);
            vin_reg.z <= sext_coord(vz);
        end
        ab_reg    <= ab_next;
        ac_reg    <= ac_next;
        ad_reg    <= ad_next;
        ao_reg    <= ao_next;
        f_reg     <= f_next;
        t_reg     <= t_next;
        e_reg     <= e_next;
        prod_reg  <= prod_next;
        tneg_reg  <= term.neg ^ cmd.mac_neg;
        tlast_reg <= term.last;
        tcomp_reg <= term.comp;
        if (cmd.out_load)
        begin
            odir_reg <= dir_reg;
            ocnt_reg <= cnt_reg;
            ohit_reg <= hit_reg;
        end
    end

    assign status.action   = act_reg;
    assign status.count    = cnt_reg;
    assign status.mac_done = mac_done;
    assign status.dot_pos  = dotpos_reg;

    assign dir_x         = odir_reg.x;
    assign dir_y         = odir_reg.y;
    assign dir_z         = odir_reg.z;
    assign simplex_count = ocnt_reg;
    assign hit           = ohit_reg;

endmodule

// ===== rtl/core/gsr_ctrl.sv =====
// Controller of the GJK simplex reducer: sequences the reduction through
// the datapath and owns both handshakes. Depends on gsr_pkg.
module gsr_ctrl
    import gsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    output logic       result_valid,
    input  logic       result_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;
    slot_t  esel_reg, esel_next;
    logic   out_valid_reg, out_valid_next;

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        esel_next  = esel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (status.action)
                    ACT_ADD:  state_next = ST_ROUTE;
                    ACT_WIND: state_next = (status.count == CNT_TETRA) ? ST_W_PREP
                                                                       : ST_FINISH;
                    default:  state_next = ST_FINISH;
                endcase
            end
            ST_ROUTE:
            begin
                case (status.count)
                    CNT_LINE: state_next = ST_L_PREP;
                    CNT_TRI:  state_next = ST_T_PREP;
                    default:  state_next = ST_Q_PREP;
                endcase
            end
            ST_L_PREP: state_next = ST_L_DOT;
            ST_L_DOT:  if (status.mac_done) state_next = ST_L_TEST;
            ST_L_TEST:
            begin
                if (status.dot_pos)
                begin
                    esel_next  = SL_AB;
                    state_next = ST_E_T;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_E_T:    if (status.mac_done) state_next = ST_E_D;
            ST_E_D:    if (status.mac_done) state_next = ST_E_SET;
            ST_E_SET:  state_next = ST_FINISH;
            ST_T_PREP: state_next = ST_T_ABC;
            ST_T_ABC:  if (status.mac_done) state_next = ST_T_X1;
            ST_T_X1:   if (status.mac_done) state_next = ST_T_D1;
            ST_T_D1:   if (status.mac_done) state_next = ST_T_C1;
            ST_T_C1:   state_next = status.dot_pos ? ST_T_D2 : ST_T_X2;
            ST_T_D2:   if (status.mac_done) state_next = ST_T_C2;
            ST_T_C2:
            begin
                if (status.dot_pos)
                begin
                    esel_next  = SL_AC;
                    state_next = ST_E_T;
                end
                else
                begin
                    state_next = ST_L_DOT;
                end
            end
            ST_T_X2:   if (status.mac_done) state_next = ST_T_D3;
            ST_T_D3:   if (status.mac_done) state_next = ST_T_C3;
            ST_T_C3:   state_next = status.dot_pos ? ST_L_DOT : ST_T_D4;
            ST_T_D4:   if (status.mac_done) state_next = ST_T_C4;
            ST_T_C4:   state_next = ST_FINISH;
            ST_Q_PREP: state_next = ST_Q_X1;
            ST_Q_X1:   if (status.mac_done) state_next = ST_Q_D1;
            ST_Q_D1:   if (status.mac_done) state_next = ST_Q_C1;
            ST_Q_C1:   state_next = status.dot_pos ? ST_T_PREP : ST_Q_X2;
            ST_Q_X2:   if (status.mac_done) state_next = ST_Q_D2;
            ST_Q_D2:   if (status.mac_done) state_next = ST_Q_C2;
            ST_Q_C2:   state_next = status.dot_pos ? ST_T_PREP : ST_Q_X3;
            ST_Q_X3:   if (status.mac_done) state_next = ST_Q_D3;
            ST_Q_D3:   if (status.mac_done) state_next = ST_Q_C3;
            ST_Q_C3:   state_next = status.dot_pos ? ST_T_PREP : ST_FINISH;
            ST_W_PREP: state_next = ST_W_X;
            ST_W_X:    if (status.mac_done) state_next = ST_W_D;
            ST_W_D:    if (status.mac_done) state_next = ST_W_C;
            ST_W_C:    state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd         = '0;
        cmd.load_in = item_valid && item_ready;
        case (state_reg)
            ST_DISPATCH:
            begin
                case (status.action)
                    ACT_START: cmd.pt_op = PT_START;
                    ACT_ADD:   cmd.pt_op = PT_PUSH;
                    default:   cmd.pt_op = PT_NONE;
                endcase
            end
            ST_L_PREP, ST_T_PREP, ST_Q_PREP:
            begin
                cmd.prep = PREP_EVAL;
            end
            ST_W_PREP:
            begin
                cmd.prep = PREP_WIND;
            end
            ST_L_DOT:
            begin
                cmd.mac_run = 1'b1; cmd.mac_op = MAC_DOT;
                cmd.wsel = SL_AB; cmd.nsel = SL_AO;
            end
            ST_L_TEST:
            begin
                if (!status.dot_pos)
                begin
                    cmd.cnt_we = 1'b1; cmd.cnt_val = CNT_POINT;
                    cmd.dir_we = 1'b1; cmd.dir_sel = SL_AO;
                end
            end
            ST_E_T:
            begin
                cmd.mac_run = 1'b1; cmd.mac_op = MAC_CROSS;
                cmd.wsel = esel_reg; cmd.nsel = SL_AO; cmd.dst = SL_E;
            end
            ST_E_D:
            begin
                cmd.mac_run = 1'b1; cmd.mac_op = MAC_CROSS;
                cmd.wsel = SL_E; cmd.nsel = esel_reg; cmd.dst = SL_T;
            end
            ST_E_SET:
            begin
                cmd.dir_we = 1'b1; cmd.dir_sel = SL_T;
            end
            ST_T_ABC, ST_Q_X1:
            begin
                cmd.mac_run = 1'b1; cmd.mac_op = MAC_CROSS;
                cmd.wsel = SL_AB; cmd.nsel = SL_AC; cmd.dst = SL_F;
            end
            ST_T_X1:
            begin
                cmd.mac_run = 1'b1; cmd.mac_op = MAC_CROSS;
                cmd.wsel = SL_F; cmd.nsel = SL_AC; cmd.dst = SL_T;
            end
            ST_T_D1, ST_T_D3:
            begin
                cmd.mac_run = 1'b1; cmd.mac_op = MAC_DOT;
                cmd.wsel = SL_T; cmd.nsel = SL_AO;
            end
            ST_T_C1, ST_T_C3:
            begin
                if (status.dot_pos)
                begin
                    cmd.cnt_we = 1'b1; cmd.cnt_val = CNT_LINE;
                end
            end
            ST_T_D2:
            begin
                cmd.mac_run = 1'b1; cmd.mac_op = MAC_DOT;
                cmd.wsel = SL_AC; cmd.nsel = SL_AO;
            end
            ST_T_C2:
            begin
                if (status.dot_pos)
                begin
                    cmd.pt_op = PT_COPY12;
                end
            end
            ST_T_X2:
            begin
                // ab x abc, taken as -(abc x ab)
                cmd.mac_run = 1'b1; cmd.mac_op = MAC_CROSS; cmd.mac_neg = 1'b1;
                cmd.wsel = SL_F; cmd.nsel = SL_AB; cmd.dst = SL_T;
            end
            ST_T_D4, ST_Q_D1, ST_Q_D2, ST_Q_D3:
            begin
                cmd.mac_run = 1'b1; cmd.mac_op = MAC_DOT;
                cmd.wsel = SL_F; cmd.nsel = SL_AO;
            end
            ST_T_C4:
            begin
                cmd.dir_we  = 1'b1; cmd.dir_sel = SL_F;
                if (!status.dot_pos)
                begin
                    cmd.dir_neg = 1'b1;
                    cmd.pt_op   = PT_SWAP12;
                end
            end
            ST_Q_C1:
            begin
                if (status.dot_pos)
                begin
                    cmd.cnt_we = 1'b1; cmd.cnt_val = CNT_TRI;
                end
            end
            ST_Q_X2:
            begin
                cmd.mac_run = 1'b1; cmd.mac_op = MAC_CROSS;
                cmd.wsel = SL_AC; cmd.nsel = SL_AD; cmd.dst = SL_F;
            end
            ST_Q_C2:
            begin
                if (status.dot_pos)
                begin
                    cmd.cnt_we = 1'b1; cmd.cnt_val = CNT_TRI;
                    cmd.pt_op  = PT_TET_ACD;
                end
            end
            ST_Q_X3:
            begin
                cmd.mac_run = 1'b1; cmd.mac_op = MAC_CROSS;
                cmd.wsel = SL_AD; cmd.nsel = SL_AB; cmd.dst = SL_F;
            end
            ST_Q_C3:
            begin
                if (status.dot_pos)
                begin
                    cmd.cnt_we = 1'b1; cmd.cnt_val = CNT_TRI;
                    cmd.pt_op  = PT_TET_ADB;
                end
                else
                begin
                    cmd.hit_set = 1'b1;
                end
            end
            ST_W_X:
            begin
                // -(v31 x v32) = v32 x v31
                cmd.mac_run = 1'b1; cmd.mac_op = MAC_CROSS;
                cmd.wsel = SL_AD; cmd.nsel = SL_AC; cmd.dst = SL_F;
            end
            ST_W_D:
            begin
                cmd.mac_run = 1'b1; cmd.mac_op = MAC_DOT;
                cmd.wsel = SL_F; cmd.nsel = SL_AB;
            end
            ST_W_C:
            begin
                if (status.dot_pos)
                begin
                    cmd.pt_op = PT_SWAP01;
                end
            end
            ST_FINISH:
            begin
                cmd.out_load = !out_valid_reg || result_ready;
            end
            default:
            begin
                cmd.pt_op = PT_NONE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            esel_reg      <= SL_AB;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            esel_reg      <= esel_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/gjk_simplex_reduce.sv =====
// GJK simplex reducer, top level: controller plus datapath.
// Depends on gsr_pkg, gsr_ifs, gsr_ctrl and gsr_datapath.
//
// Usage: send one word per GJK step on item (action, vx, vy, vz). A start
// word seeds the simplex with one point and clears the hit flag; an add
// word pushes a point and reduces the simplex to the feature nearest the
// origin; a winding word swaps the two newest points of an inverted
// tetrahedron. Every word returns exactly one result word: the current
// search direction, the number of points kept and the hit flag.
// Start, winding with fewer than four points and unused codes go from
// dispatch straight to the result; a line, a triangle, a tetrahedron and
// a full winding check run a sequence of cross and dot products on the
// single shared 56x18 multiplier. One word is in work at a time;
// item.ready stays low from accept until the result is loaded and rises
// the cycle after.
// Reset clears the simplex to one point at the origin, a zero direction
// and no hit. A stalled result holds in the output register; the next
// word is still accepted and waits at its end until that register frees.
module gjk_simplex_reduce
    import gsr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    gsr_item_if.sink     item,
    gsr_result_if.source result
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    gsr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    gsr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .action        (item.action),
        .vx            (item.vx),
        .vy            (item.vy),
        .vz            (item.vz),
        .dir_x         (result.dir_x),
        .dir_y         (result.dir_y),
        .dir_z         (result.dir_z),
        .simplex_count (result.simplex_count),
        .hit           (result.hit)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("accepted a word while another was in work");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.simplex_count >= CNT_POINT &&
                          result.simplex_count <= CNT_TETRA))
        else $error("result simplex count out of range");

    a_hit_needs_tetra: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hit_set |-> (status.count == CNT_TETRA))
        else $error("hit flag set without a full simplex");

endmodule
